### hw/rtl/gamepad_input_qualifier_defines.svh
// Assertion macros used by the gamepad input qualifier RTL.
`ifndef GAMEPAD_INPUT_QUALIFIER_DEFINES_SVH
`define GAMEPAD_INPUT_QUALIFIER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/gpq_pkg.sv
// Types, constants and helper functions shared by the gamepad input qualifier.
package gpq_pkg;

	// Fixed field widths.
	localparam int ButtonW   = 16;
	localparam int TriggerW  = 8;
	localparam int AxisW     = 16;
	localparam int DirW      = 4;
	localparam int HoldOutW  = 7;
	localparam int DeadzoneW = 32;
	localparam int SelW      = 4;
	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 32;

	// Product widths for the stick classification.
	localparam int SqW     = 31;
	localparam int MagW    = 32;
	localparam int LhsW    = 32;
	localparam int LoProdW = 30;
	localparam int HiProdW = 33;

	// Default parameter values.
	localparam int HistoryDepthDefault = 64;
	localparam int ButtonCountDefault  = 16;

	// tan(22.5 deg) and tan(67.5 deg) in Q16, rounded to nearest.
	localparam logic [17:0] TAN_LO_Q16 = 18'd27146;
	localparam logic [17:0] TAN_HI_Q16 = 18'd158218;

	// Direction codes.
	localparam logic [DirW-1:0] DIR_NONE       = 4'd0;
	localparam logic [DirW-1:0] DIR_LEFT       = 4'd1;
	localparam logic [DirW-1:0] DIR_DOWN_LEFT  = 4'd2;
	localparam logic [DirW-1:0] DIR_DOWN       = 4'd3;
	localparam logic [DirW-1:0] DIR_DOWN_RIGHT = 4'd4;
	localparam logic [DirW-1:0] DIR_RIGHT      = 4'd5;
	localparam logic [DirW-1:0] DIR_UP_RIGHT   = 4'd6;
	localparam logic [DirW-1:0] DIR_UP         = 4'd7;
	localparam logic [DirW-1:0] DIR_UP_LEFT    = 4'd8;

	// Configuration register indexes.
	localparam logic [CfgIndexW-1:0] CFG_TRIGGER_THRESHOLD  = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_STICK_DEADZONE_SQ  = 2'd1;
	localparam logic [CfgIndexW-1:0] CFG_INCLUDE_STICK      = 2'd2;
	localparam logic [CfgIndexW-1:0] CFG_HOLD_BUTTON_SELECT = 2'd3;

	typedef struct packed {
		logic [ButtonW-1:0]        button_bits;
		logic [TriggerW-1:0]       left_trigger;
		logic [TriggerW-1:0]       right_trigger;
		logic signed [AxisW-1:0]   left_x;
		logic signed [AxisW-1:0]   left_y;
		logic signed [AxisW-1:0]   right_x;
		logic signed [AxisW-1:0]   right_y;
	} gpq_in_t;

	typedef struct packed {
		logic [ButtonW-1:0]  held_mask;
		logic [ButtonW-1:0]  pressed_mask;
		logic [ButtonW-1:0]  released_mask;
		logic                any_active;
		logic                any_new;
		logic [DirW-1:0]     left_dir;
		logic [DirW-1:0]     right_dir;
		logic [DirW-1:0]     left_dir_new;
		logic [DirW-1:0]     right_dir_new;
		logic [HoldOutW-1:0] hold_frames;
	} gpq_out_t;

	typedef struct packed {
		logic [TriggerW-1:0]  trigger_threshold;
		logic [DeadzoneW-1:0] stick_deadzone_sq;
		logic                 include_stick;
		logic [SelW-1:0]      hold_button_select;
	} gpq_cfg_t;

	// Squares and octant products of one stick.
	typedef struct packed {
		logic [SqW-1:0]     ax_sq;
		logic [SqW-1:0]     ay_sq;
		logic [LhsW-1:0]    lhs;
		logic [LoProdW-1:0] lo_prod;
		logic [HiProdW-1:0] hi_prod;
		logic               x_pos;
		logic               y_pos;
	} gpq_prod_t;

	// Second pipeline stage: raw buttons and triggers plus stick products.
	typedef struct packed {
		logic [ButtonW-1:0]  button_bits;
		logic [TriggerW-1:0] left_trigger;
		logic [TriggerW-1:0] right_trigger;
		gpq_prod_t           left;
		gpq_prod_t           right;
	} gpq_prod_stage_t;

	// Third pipeline stage: raw buttons and triggers plus directions.
	typedef struct packed {
		logic [ButtonW-1:0]  button_bits;
		logic [TriggerW-1:0] left_trigger;
		logic [TriggerW-1:0] right_trigger;
		logic [DirW-1:0]     left_dir;
		logic [DirW-1:0]     right_dir;
	} gpq_dir_stage_t;

	// Mask of the buttons that exist.
	function automatic logic [ButtonW-1:0] gpq_button_mask(input int count);
		logic [ButtonW-1:0] mask;
		mask = '0;
		for (int i = 0; i < ButtonW; i++) begin
			mask[i] = (i < count);
		end
		return mask;
	endfunction

endpackage

### hw/rtl/gamepad_input_qualifier.sv
// Gamepad input qualifier: four register stages (input, stick products,
// stick directions, result) each hold one item and refill as soon as they drain;
// throughput is one item per cycle while result_stall does not hold the result.
// The input stall follows the result stall through the stage occupancy in the same cycle.
// Reset clears all stage valid flags, configuration registers and frame history
// (previous buttons, any-input, directions, hold counters, frame count).
module gamepad_input_qualifier
	import gpq_pkg::*;
#(
	parameter int HISTORY_DEPTH = HistoryDepthDefault,
	parameter int BUTTON_COUNT  = ButtonCountDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  gpq_in_t              item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output gpq_out_t             result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	gpq_cfg_t        cfg_q;
	logic            v_s1;
	logic            v_s2;
	logic            v_s3;
	gpq_in_t         data_s1;
	gpq_prod_stage_t data_s2;
	gpq_dir_stage_t  data_s3;
	gpq_prod_t       left_prod;
	gpq_prod_t       right_prod;
	logic [DirW-1:0] left_dir;
	logic [DirW-1:0] right_dir;
	logic            track_ready;
	logic            rdy_s1;
	logic            rdy_s2;
	logic            rdy_s3;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TRIGGER_THRESHOLD:  cfg_q.trigger_threshold  <= cfg_data[TriggerW-1:0];
				CFG_STICK_DEADZONE_SQ:  cfg_q.stick_deadzone_sq  <= cfg_data[DeadzoneW-1:0];
				CFG_INCLUDE_STICK:      cfg_q.include_stick      <= cfg_data[0];
				CFG_HOLD_BUTTON_SELECT: cfg_q.hold_button_select <= cfg_data[SelW-1:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its contents move on.
	assign rdy_s3     = !v_s3 || track_ready;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign item_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= item_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stick products from the registered input.
	gpq_stick_mult u_left_mult (
		.x    (data_s1.left_x),
		.y    (data_s1.left_y),
		.prod (left_prod)
	);

	gpq_stick_mult u_right_mult (
		.x    (data_s1.right_x),
		.y    (data_s1.right_y),
		.prod (right_prod)
	);

	// Directions from the registered products.
	gpq_stick_dir u_left_dir (
		.prod        (data_s2.left),
		.deadzone_sq (cfg_q.stick_deadzone_sq),
		.dir         (left_dir)
	);

	gpq_stick_dir u_right_dir (
		.prod        (data_s2.right),
		.deadzone_sq (cfg_q.stick_deadzone_sq),
		.dir         (right_dir)
	);

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (rdy_s1 && item_valid) begin
			data_s1 <= item;
		end
		if (rdy_s2 && v_s1) begin
			data_s2.button_bits   <= data_s1.button_bits;
			data_s2.left_trigger  <= data_s1.left_trigger;
			data_s2.right_trigger <= data_s1.right_trigger;
			data_s2.left          <= left_prod;
			data_s2.right         <= right_prod;
		end
		if (rdy_s3 && v_s2) begin
			data_s3.button_bits   <= data_s2.button_bits;
			data_s3.left_trigger  <= data_s2.left_trigger;
			data_s3.right_trigger <= data_s2.right_trigger;
			data_s3.left_dir      <= left_dir;
			data_s3.right_dir     <= right_dir;
		end
	end

	// Frame history and result register.
	gpq_track #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.BUTTON_COUNT  (BUTTON_COUNT)
	) u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.take_valid   (v_s3),
		.take_ready   (track_ready),
		.stage        (data_s3),
		.cfg          (cfg_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### hw/rtl/gpq_stick_mult.sv
// Absolute values, squares and octant boundary products of one stick.
module gpq_stick_mult
	import gpq_pkg::*;
(
	input  logic signed [AxisW-1:0] x,
	input  logic signed [AxisW-1:0] y,
	output gpq_prod_t               prod
);

	logic [AxisW-1:0] ax;
	logic [AxisW-1:0] ay;
	logic [31:0]      ax_sq_full;
	logic [31:0]      ay_sq_full;
	logic [33:0]      lo_full;
	logic [33:0]      hi_full;

	// Magnitudes; the most negative value maps to 32768, which fits unsigned.
	assign ax = x[AxisW-1] ? (~x + 16'd1) : x;
	assign ay = y[AxisW-1] ? (~y + 16'd1) : y;

	// Squares for the deadzone test.
	assign ax_sq_full = 32'(ax) * 32'(ax);
	assign ay_sq_full = 32'(ay) * 32'(ay);

	// Octant boundaries scaled to Q16.
	assign lo_full = 34'(ax) * 34'(TAN_LO_Q16);
	assign hi_full = 34'(ax) * 34'(TAN_HI_Q16);

	always_comb begin
		prod.ax_sq   = ax_sq_full[SqW-1:0];
		prod.ay_sq   = ay_sq_full[SqW-1:0];
		prod.lhs     = {ay, 16'd0};
		prod.lo_prod = lo_full[LoProdW-1:0];
		prod.hi_prod = hi_full[HiProdW-1:0];
		prod.x_pos   = !x[AxisW-1] && (x != '0);
		prod.y_pos   = !y[AxisW-1] && (y != '0);
	end

endmodule

### hw/rtl/gpq_stick_dir.sv
// Eight-way direction of one stick from its registered products.
module gpq_stick_dir
	import gpq_pkg::*;
(
	input  gpq_prod_t            prod,
	input  logic [DeadzoneW-1:0] deadzone_sq,
	output logic [DirW-1:0]      dir
);

	logic [MagW-1:0] mag;
	logic            horizontal;
	logic            vertical;

	// Squared magnitude and octant comparisons.
	assign mag        = MagW'(prod.ax_sq) + MagW'(prod.ay_sq);
	assign horizontal = prod.lhs < LhsW'(prod.lo_prod);
	assign vertical   = HiProdW'(prod.lhs) >= prod.hi_prod;

	// Pick the direction; the deadzone wins, then horizontal, then vertical.
	always_comb begin
		priority if (mag <= deadzone_sq) begin
			dir = DIR_NONE;
		end else if (horizontal) begin
			dir = prod.x_pos ? DIR_RIGHT : DIR_LEFT;
		end else if (vertical) begin
			dir = prod.y_pos ? DIR_UP : DIR_DOWN;
		end else if (prod.y_pos) begin
			dir = prod.x_pos ? DIR_UP_RIGHT : DIR_UP_LEFT;
		end else begin
			dir = prod.x_pos ? DIR_DOWN_RIGHT : DIR_DOWN_LEFT;
		end
	end

endmodule

### hw/rtl/gpq_track.sv
// Frame history state, edge and hold reporting, and the result register.
`include "gamepad_input_qualifier_defines.svh"

module gpq_track
	import gpq_pkg::*;
#(
	parameter int HISTORY_DEPTH = HistoryDepthDefault,
	parameter int BUTTON_COUNT  = ButtonCountDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take_valid,
	output logic           take_ready,
	input  gpq_dir_stage_t stage,
	input  gpq_cfg_t       cfg,
	output logic           result_valid,
	input  logic           result_stall,
	output gpq_out_t       result
);

	localparam int HoldW = $clog2(HISTORY_DEPTH + 1);
	localparam int ExtW  = (HoldW > HoldOutW) ? HoldW : HoldOutW;
	localparam logic [ButtonW-1:0] BtnMask = gpq_button_mask(BUTTON_COUNT);

	logic [ButtonW-1:0] last_buttons_q;
	logic               last_any_q;
	logic [DirW-1:0]    last_left_dir_q;
	logic [DirW-1:0]    last_right_dir_q;
	logic [1:0]         frames_q;
	logic [HoldW-1:0]   hold_q [ButtonW];
	logic [HoldW-1:0]   hold_next [ButtonW];

	logic               take;
	logic [ButtonW-1:0] btn;
	logic               first;
	logic [1:0]         frames_next;
	logic               any;
	logic [ExtW-1:0]    hold_ext;
	gpq_out_t           result_d;
	gpq_out_t           result_q;
	logic               result_valid_q;

	// A transfer into the result register happens when it is empty or being drained.
	assign take_ready = !result_valid_q || !result_stall;
	assign take       = take_valid && take_ready;

	assign btn         = stage.button_bits & BtnMask;
	assign first       = (frames_q == 2'd0);
	assign frames_next = (frames_q == 2'd3) ? frames_q : frames_q + 2'd1;

	// Any-input flag from buttons, triggers and optionally the sticks.
	always_comb begin
		any = (btn != '0)
			|| (stage.left_trigger > cfg.trigger_threshold)
			|| (stage.right_trigger > cfg.trigger_threshold)
			|| (cfg.include_stick
				&& ((stage.left_dir != DIR_NONE) || (stage.right_dir != DIR_NONE)));
	end

	// Per-button hold counters, saturating at the history depth.
	always_comb begin
		for (int i = 0; i < ButtonW; i++) begin
			if (!btn[i]) begin
				hold_next[i] = '0;
			end else if (hold_q[i] < HoldW'(HISTORY_DEPTH)) begin
				hold_next[i] = hold_q[i] + HoldW'(1);
			end else begin
				hold_next[i] = hold_q[i];
			end
		end
	end

	assign hold_ext = ExtW'(hold_next[cfg.hold_button_select]);

	// Result fields for the frame in the last stage.
	always_comb begin
		result_d.held_mask     = btn;
		result_d.pressed_mask  = first ? '0 : (btn & ~last_buttons_q);
		result_d.released_mask = first ? '0 : (~btn & last_buttons_q);
		result_d.any_active    = any;
		result_d.any_new       = any && !last_any_q && (frames_next == 2'd3);
		result_d.left_dir      = stage.left_dir;
		result_d.right_dir     = stage.right_dir;
		result_d.left_dir_new  = (!first && (stage.left_dir != last_left_dir_q))
			? stage.left_dir : DIR_NONE;
		result_d.right_dir_new = (!first && (stage.right_dir != last_right_dir_q))
			? stage.right_dir : DIR_NONE;
		result_d.hold_frames   = hold_ext[HoldOutW-1:0];
	end

	// Frame history, updated once per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_buttons_q   <= '0;
			last_any_q       <= 1'b0;
			last_left_dir_q  <= DIR_NONE;
			last_right_dir_q <= DIR_NONE;
			frames_q         <= 2'd0;
			for (int i = 0; i < ButtonW; i++) begin
				hold_q[i] <= '0;
			end
		end else if (take) begin
			last_buttons_q   <= btn;
			last_any_q       <= any;
			last_left_dir_q  <= stage.left_dir;
			last_right_dir_q <= stage.right_dir;
			frames_q         <= frames_next;
			for (int i = 0; i < ButtonW; i++) begin
				hold_q[i] <= hold_next[i];
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take_ready) begin
			result_valid_q <= take_valid;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Consistency of the reported frame.
	`GPQ_ASSERT_NOW(a_press_release_disjoint, clk, arst_n, result_valid_q, (result_q.pressed_mask & result_q.released_mask) == '0, "pressed and released overlap")
	`GPQ_ASSERT_NOW(a_new_needs_active, clk, arst_n, result_valid_q && result_q.any_new, result_q.any_active, "any_new without any_active")
	`GPQ_ASSERT_NOW(a_left_new_matches, clk, arst_n, result_valid_q && (result_q.left_dir_new != DIR_NONE), result_q.left_dir_new == result_q.left_dir, "left_dir_new differs from left_dir")
	`GPQ_ASSERT_NOW(a_hold_needs_held, clk, arst_n, result_valid_q && (result_q.hold_frames != '0), result_q.held_mask[cfg.hold_button_select], "hold count on a released button")
	`GPQ_ASSERT_NEXT(a_frame_counted, clk, arst_n, take, frames_q != 2'd0, "frame count did not advance")

endmodule
